// ----- hdl/rollseq_pkg.sv -----
// rollseq_pkg: shared types, codes and reset values for the roller stall
// slowdown and arm sequencer; no dependencies
`default_nettype none

package rollseq_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DUTY_W      = 16;
  localparam int TICKS_W     = 10;
  localparam int CURRENT_W   = 12;
  localparam int BAND_W      = 3;
  localparam int SLOW_CNT_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_RUN_DUTY      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_DUTY     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_HOLD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTEND_DELAY  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRACT_DELAY = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_LOW   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_HIGH  = 3'd6;

  localparam logic signed [DUTY_W-1:0] RST_RUN_DUTY      = 16'sd16384;
  localparam logic signed [DUTY_W-1:0] RST_SLOW_DUTY     = 16'sd8192;
  localparam logic [TICKS_W-1:0]       RST_SLOW_HOLD     = 10'd50;
  localparam logic [TICKS_W-1:0]       RST_EXTEND_DELAY  = 10'd15;
  localparam logic [TICKS_W-1:0]       RST_RETRACT_DELAY = 10'd15;
  localparam logic [CURRENT_W-1:0]     RST_CURRENT_LOW   = 12'd224;
  localparam logic [CURRENT_W-1:0]     RST_CURRENT_HIGH  = 12'd320;

  localparam logic [BAND_W-1:0]     BAND_MAX     = 3'd7;
  localparam logic [BAND_W-1:0]     BAND_TRIGGER = 3'd5;
  localparam logic [SLOW_CNT_W-1:0] SLOW_CNT_MAX = 11'd2047;

  localparam logic signed [DUTY_W-1:0] DUTY_MOST_NEG = 16'sh8000;
  localparam logic signed [DUTY_W-1:0] DUTY_MOST_POS = 16'sh7fff;

  localparam logic [1:0] DIR_NONE    = 2'b00;
  localparam logic [1:0] DIR_FORWARD = 2'b01;

  localparam logic [1:0] VALVE_NONE    = 2'd0;
  localparam logic [1:0] VALVE_EXTEND  = 2'd1;
  localparam logic [1:0] VALVE_RETRACT = 2'd2;

  localparam logic [1:0] LAUNCH_NONE = 2'd0;
  localparam logic [1:0] LAUNCH_LOW  = 2'd1;
  localparam logic [1:0] LAUNCH_HIGH = 2'd2;

  typedef struct packed {
    logic signed [DUTY_W-1:0] run_duty;
    logic signed [DUTY_W-1:0] slow_duty;
    logic [TICKS_W-1:0]       slow_hold_ticks;
    logic [TICKS_W-1:0]       extend_delay;
    logic [TICKS_W-1:0]       retract_delay;
    logic [CURRENT_W-1:0]     current_low;
    logic [CURRENT_W-1:0]     current_high;
  } cfg_t;

  typedef struct packed {
    logic                  force_down;
    logic                  run_rollers;
    logic signed [1:0]     roller_dir;
    logic                  arm_down;
    logic [CURRENT_W-1:0]  motor_current;
  } tick_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] motor_duty;
    logic [1:0]               valve_cmd;
    logic [1:0]               launcher_cmd;
    logic                     slowing;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/rollseq_cfg_regs.sv -----
// rollseq_cfg_regs: configuration register file with plain write port
// depends on rollseq_pkg
`default_nettype none

module rollseq_cfg_regs
  import rollseq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_duty        <= RST_RUN_DUTY;
      cfg.slow_duty       <= RST_SLOW_DUTY;
      cfg.slow_hold_ticks <= RST_SLOW_HOLD;
      cfg.extend_delay    <= RST_EXTEND_DELAY;
      cfg.retract_delay   <= RST_RETRACT_DELAY;
      cfg.current_low     <= RST_CURRENT_LOW;
      cfg.current_high    <= RST_CURRENT_HIGH;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_RUN_DUTY:      cfg.run_duty        <= cfg_data;
        CFG_SLOW_DUTY:     cfg.slow_duty       <= cfg_data;
        CFG_SLOW_HOLD:     cfg.slow_hold_ticks <= cfg_data[TICKS_W-1:0];
        CFG_EXTEND_DELAY:  cfg.extend_delay    <= cfg_data[TICKS_W-1:0];
        CFG_RETRACT_DELAY: cfg.retract_delay   <= cfg_data[TICKS_W-1:0];
        CFG_CURRENT_LOW:   cfg.current_low     <= cfg_data[CURRENT_W-1:0];
        CFG_CURRENT_HIGH:  cfg.current_high    <= cfg_data[CURRENT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rollseq_core.sv -----
// rollseq_core: per-tick state registers and the single-pass next-state and
// result logic; depends on rollseq_pkg
`default_nettype none

module rollseq_core
  import rollseq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire tick_t   tick,
  input  wire cfg_t    cfg,
  output result_t      result
);

  logic [BAND_W-1:0]     band_count;
  logic                  slow_active;
  logic [SLOW_CNT_W-1:0] slow_ticks;
  logic [TICKS_W-1:0]    delay_left;
  logic                  last_was_up;

  logic [BAND_W-1:0]     band_count_next;
  logic                  slow_active_next;
  logic [SLOW_CNT_W-1:0] slow_ticks_next;
  logic [TICKS_W-1:0]    delay_left_next;
  logic                  last_was_up_next;

  logic                     in_band;
  logic [BAND_W-1:0]        band_inc;
  logic                     slow_set;
  logic [SLOW_CNT_W-1:0]    ticks_inc;
  logic                     slow_done;
  logic signed [DUTY_W-1:0] base_duty;
  logic signed [DUTY_W-1:0] dir_duty;
  logic                     arm_change;

  always_comb begin
    in_band  = (tick.motor_current > cfg.current_low) &&
               (tick.motor_current < cfg.current_high);
    band_inc = in_band ? ((band_count == BAND_MAX) ? BAND_MAX : band_count + 3'd1)
                       : '0;
    slow_set = slow_active || (band_inc > BAND_TRIGGER);
    if (slow_set) begin
      ticks_inc = (slow_ticks == SLOW_CNT_MAX) ? SLOW_CNT_MAX : slow_ticks + 11'd1;
    end else begin
      ticks_inc = slow_ticks;
    end
    slow_done = ticks_inc > {1'b0, cfg.slow_hold_ticks};
    base_duty = slow_set ? cfg.slow_duty : cfg.run_duty;
    case (tick.roller_dir)
      DIR_NONE:    dir_duty = '0;
      DIR_FORWARD: dir_duty = base_duty;
      default:     dir_duty = (base_duty == DUTY_MOST_NEG) ? DUTY_MOST_POS : -base_duty;
    endcase
  end

  always_comb begin
    band_count_next  = band_count;
    slow_active_next = slow_active;
    slow_ticks_next  = slow_ticks;
    delay_left_next  = delay_left;
    last_was_up_next = last_was_up;
    result.motor_duty   = '0;
    result.valve_cmd    = VALVE_NONE;
    result.launcher_cmd = LAUNCH_NONE;
    arm_change = (last_was_up == tick.arm_down);

    if (tick.force_down) begin
      result.valve_cmd = VALVE_EXTEND;
    end else begin
      if (tick.run_rollers) begin
        band_count_next   = band_inc;
        result.motor_duty = dir_duty;
        if (slow_done) begin
          slow_ticks_next  = '0;
          slow_active_next = 1'b0;
        end else begin
          slow_ticks_next  = ticks_inc;
          slow_active_next = slow_set;
        end
      end
      if (arm_change) begin
        result.launcher_cmd = LAUNCH_LOW;
        if (tick.arm_down) begin
          result.valve_cmd = VALVE_EXTEND;
          delay_left_next  = cfg.extend_delay;
        end else begin
          delay_left_next  = cfg.retract_delay;
        end
      end else if (tick.arm_down) begin
        result.valve_cmd = VALVE_EXTEND;
        if (delay_left != '0) begin
          delay_left_next = delay_left - 10'd1;
        end else begin
          result.launcher_cmd = LAUNCH_HIGH;
        end
      end else begin
        if (delay_left != '0) begin
          delay_left_next = delay_left - 10'd1;
        end else begin
          result.valve_cmd = VALVE_RETRACT;
        end
      end
      last_was_up_next = !tick.arm_down;
    end
    result.slowing = slow_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count  <= '0;
      slow_active <= 1'b0;
      slow_ticks  <= '0;
      delay_left  <= '0;
      last_was_up <= 1'b1;
    end else if (accept) begin
      band_count  <= band_count_next;
      slow_active <= slow_active_next;
      slow_ticks  <= slow_ticks_next;
      delay_left  <= delay_left_next;
      last_was_up <= last_was_up_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rollseq_out_buf.sv -----
// rollseq_out_buf: result register with a skid stage behind it
// depends on rollseq_pkg
`default_nettype none

module rollseq_out_buf
  import rollseq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         head_valid,
  input  wire logic    pop,
  output result_t      head_data
);

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        head_data <= skid_data;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        head_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/roller_stall_slowdown_and_arm_sequencer.sv -----
// roller_stall_slowdown_and_arm_sequencer: top level of the roller sequencer
// depends on rollseq_pkg, rollseq_cfg_regs, rollseq_core, rollseq_out_buf
//
// one input beat is one control tick; each tick yields exactly one result beat
// input channel: in_valid/in_stall carrying force_down, run_rollers,
//   roller_dir, arm_down and motor_current
// output channel: out_valid/out_stall carrying motor_duty, valve_cmd,
//   launcher_cmd and slowing
// config: cfg_write_en/cfg_index/cfg_data, register i at index i, write only,
//   change only while no tick is in flight
// result beat: registered, shown in the cycle after the input beat when the output is free
// throughput: 1 tick per cycle while in_stall is low; tick state is updated in the accept cycle
//   and the result lands in the output register
// a two-entry output buffer (result register plus skid) lets one more tick
//   enter while a result waits; in_stall rises once both entries hold beats
// reset: synchronous, clears the buffer and tick state, loads default
//   config values; in_stall is high while rst is high
// receiver stall: out_valid and the result hold until out_stall drops
`default_nettype none

module roller_stall_slowdown_and_arm_sequencer
  import rollseq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   force_down,
  input  wire logic                   run_rollers,
  input  wire logic signed [1:0]      roller_dir,
  input  wire logic                   arm_down,
  input  wire logic [CURRENT_W-1:0]   motor_current,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [DUTY_W-1:0]    motor_duty,
  output logic [1:0]                  valve_cmd,
  output logic [1:0]                  launcher_cmd,
  output logic                        slowing
);

  cfg_t    cfg;
  tick_t   tick;
  result_t core_result;
  result_t head_data;
  logic    buf_full;
  logic    accept;
  logic    pop;

  assign in_stall = rst || buf_full;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  assign tick.force_down    = force_down;
  assign tick.run_rollers   = run_rollers;
  assign tick.roller_dir    = roller_dir;
  assign tick.arm_down      = arm_down;
  assign tick.motor_current = motor_current;

  rollseq_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  rollseq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .tick   (tick),
    .cfg    (cfg),
    .result (core_result)
  );

  rollseq_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (core_result),
    .full       (buf_full),
    .head_valid (out_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  assign motor_duty   = head_data.motor_duty;
  assign valve_cmd    = head_data.valve_cmd;
  assign launcher_cmd = head_data.launcher_cmd;
  assign slowing      = head_data.slowing;

endmodule

`default_nettype wire

// ----- hdl/rollseq_checker.sv -----
// rollseq_port_checks: port-level checks for the roller sequencer, bound to
// the top level; depends on rollseq_pkg
`default_nettype none

module rollseq_port_checks
  import rollseq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   force_down,
  input wire logic                   run_rollers,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic signed [DUTY_W-1:0] motor_duty,
  input wire logic [1:0]             valve_cmd,
  input wire logic [1:0]             launcher_cmd
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_duty) &&
      $stable(valve_cmd) && $stable(launcher_cmd))
    else $error("stalled result beat changed");

  // an input beat into an empty output shows a result next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_beat && !out_valid |=> out_valid)
    else $error("result beat missing one cycle after input beat");

  // force down gives extend, no motor, no launcher
  a_force: assert property (@(posedge clk) disable iff (rst)
    in_beat && !out_valid && force_down |=> motor_duty == '0 &&
      valve_cmd == VALVE_EXTEND && launcher_cmd == LAUNCH_NONE)
    else $error("force down result wrong");

  // stopped rollers give zero duty
  a_stopped: assert property (@(posedge clk) disable iff (rst)
    in_beat && !out_valid && !run_rollers |=> motor_duty == '0)
    else $error("duty nonzero with rollers stopped");

  // launcher high only with arm extended
  a_launch_arm: assert property (@(posedge clk) disable iff (rst)
    out_valid && launcher_cmd == LAUNCH_HIGH |-> valve_cmd == VALVE_EXTEND)
    else $error("launcher high without arm extend");

endmodule

bind roller_stall_slowdown_and_arm_sequencer rollseq_port_checks u_rollseq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .force_down   (force_down),
  .run_rollers  (run_rollers),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .motor_duty   (motor_duty),
  .valve_cmd    (valve_cmd),
  .launcher_cmd (launcher_cmd)
);

`default_nettype wire
